// ----- rtl/ata_pio_command_sequencer_assert.svh -----
// Assertion macros for the ATA PIO command sequencer
`ifndef ATA_PIO_COMMAND_SEQUENCER_ASSERT_SVH
`define ATA_PIO_COMMAND_SEQUENCER_ASSERT_SVH
`ifndef SYNTHESIS
`define APS_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define APS_ASSERT_NR(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define APS_ASSERT(label, clk, rstn, prop, msg)
`define APS_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

// ----- rtl/aps_pkg.sv -----
// ----------------------------------------------------------------------------
// aps_pkg
// Types, codes and constants shared by the sequencer modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package aps_pkg;
    localparam int WORDS_PER_SECTOR_DEF = 256;
    localparam int MAX_BATCH_DEF        = 255;

    localparam logic [2:0] ACT_READ  = 3'd0;
    localparam logic [2:0] ACT_WRITE = 3'd1;
    localparam logic [2:0] ACT_IDENT = 3'd2;
    localparam logic [2:0] ACT_RESP  = 3'd3;
    localparam logic [2:0] ACT_WWORD = 3'd4;

    localparam logic [2:0] RK_BUS   = 3'd0;
    localparam logic [2:0] RK_HWORD = 3'd1;
    localparam logic [2:0] RK_WREQ  = 3'd2;
    localparam logic [2:0] RK_DONE  = 3'd3;

    localparam logic [2:0] OP_NONE = 3'd0;
    localparam logic [2:0] OP_WR8  = 3'd1;
    localparam logic [2:0] OP_RD8  = 3'd2;
    localparam logic [2:0] OP_RD16 = 3'd3;
    localparam logic [2:0] OP_WR16 = 3'd4;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_INVALID  = 3'd1;
    localparam logic [2:0] ST_NOTFOUND = 3'd2;
    localparam logic [2:0] ST_DEVERR   = 3'd3;
    localparam logic [2:0] ST_TIMEOUT  = 3'd4;
    localparam logic [2:0] ST_UNSUP    = 3'd5;

    localparam logic [1:0] K_READ  = 2'd0;
    localparam logic [1:0] K_WRITE = 2'd1;
    localparam logic [1:0] K_IDENT = 2'd2;

    localparam logic [1:0] CFG_CMD_BASE  = 2'd0;
    localparam logic [1:0] CFG_CTRL_BASE = 2'd1;
    localparam logic [1:0] CFG_SLAVE     = 2'd2;
    localparam logic [1:0] CFG_POLL      = 2'd3;

    localparam logic [7:0] SEL_LBA   = 8'hE0;
    localparam logic [7:0] SEL_CHS   = 8'hA0;
    localparam logic [7:0] SEL_SLAVE = 8'h10;
    localparam logic [7:0] CMD_RD    = 8'h20;
    localparam logic [7:0] CMD_WR    = 8'h30;
    localparam logic [7:0] CMD_FLUSH = 8'hE7;
    localparam logic [7:0] CMD_IDENT = 8'hEC;

    // queued front item
    typedef struct packed {
        logic [2:0]  action;
        logic [27:0] lba;
        logic [15:0] sector_count;
        logic [15:0] value;
    } item_t;

    // one result
    typedef struct packed {
        logic [2:0]  kind;
        logic [2:0]  op;
        logic [15:0] port;
        logic [15:0] data;
        logic [15:0] hword;
        logic [2:0]  status;
        logic [47:0] sectors;
        logic        last;
    } res_t;

    typedef struct packed {
        logic [15:0] cmd_base;
        logic [15:0] ctrl_base;
        logic        slave;
        logic [21:0] poll_limit;
    } cfg_t;
endpackage
`default_nettype wire

// ----- rtl/ata_pio_command_sequencer.sv -----
// ----------------------------------------------------------------------------
// ata_pio_command_sequencer
// Host-side ATA PIO sequencer for IDENTIFY and LBA28 read and write.
// ----------------------------------------------------------------------------
// Items enter a two-entry queue; the sequencer takes one when it is not busy and its
// result register is free, and emits its results through that single register, one a
// cycle while m_tready accepts them.
`timescale 1ns / 1ps
`default_nettype none
module ata_pio_command_sequencer #(
    parameter int WORDS_PER_SECTOR = aps_pkg::WORDS_PER_SECTOR_DEF,
    parameter int MAX_BATCH        = aps_pkg::MAX_BATCH_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [21:0] cfg_data,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // action[2:0] lba[30:3] sector_count[46:31] bus_value[62:47] write_word[78:63]
    input  wire logic [79:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // result_kind[2:0] bus_op[5:3] bus_port[21:6] bus_data[37:22] host_word[53:38]
    // status_code[56:54] disk_sectors[104:57]
    output logic [111:0]     m_tdata,
    output logic             m_tlast
);
    import aps_pkg::*;
    cfg_t  cfg_reg;
    item_t in_item, q_item;
    logic  q_valid, q_ready;
    res_t  res;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.cmd_base   <= 16'd496;
            cfg_reg.ctrl_base  <= 16'd1014;
            cfg_reg.slave      <= 1'b0;
            cfg_reg.poll_limit <= 22'd2000000;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_CMD_BASE:  cfg_reg.cmd_base   <= cfg_data[15:0];
                CFG_CTRL_BASE: cfg_reg.ctrl_base  <= cfg_data[15:0];
                CFG_SLAVE:     cfg_reg.slave      <= cfg_data[0];
                CFG_POLL:      cfg_reg.poll_limit <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        in_item.action       = s_tdata[2:0];
        in_item.lba          = s_tdata[30:3];
        in_item.sector_count = s_tdata[46:31];
        in_item.value        = (s_tdata[2:0] == ACT_WWORD) ? s_tdata[78:63] : s_tdata[62:47];
    end

    aps_front u_front (
        .aclk(aclk), .aresetn(aresetn), .in_valid(s_tvalid), .in_ready(s_tready),
        .in_item(in_item), .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item)
    );

    aps_back #(.WORDS_PER_SECTOR(WORDS_PER_SECTOR), .MAX_BATCH(MAX_BATCH)) u_back (
        .aclk(aclk), .aresetn(aresetn), .cfg(cfg_reg), .q_valid(q_valid),
        .q_ready(q_ready), .q_item(q_item), .m_valid(m_tvalid), .m_ready(m_tready),
        .m_res(res)
    );

    assign m_tdata = {7'd0, res.sectors, res.status, res.hword, res.data, res.port,
                      res.op, res.kind};
    assign m_tlast = res.last;
endmodule
`default_nettype wire

// ----- rtl/aps_front.sv -----
// ----------------------------------------------------------------------------
// aps_front
// Accepts items, drops undefined actions, and keeps a two-entry queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "ata_pio_command_sequencer_assert.svh"
module aps_front (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire aps_pkg::item_t in_item,
    output logic                q_valid,
    input  wire logic           q_ready,
    output aps_pkg::item_t      q_item
);
    import aps_pkg::*;
    item_t      mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       push, pop, keep;

    assign in_ready = (cnt_reg != 2'd2);
    assign keep     = (in_item.action <= ACT_WWORD);
    assign push     = in_valid && in_ready && keep;
    assign pop      = q_valid && q_ready;
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_item   = mem_reg[rp_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (push) wp_reg <= ~wp_reg;
            if (pop) rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge aclk) begin
        if (push) mem_reg[wp_reg] <= in_item;
    end

    `APS_ASSERT(a_no_overflow, aclk, aresetn, !(cnt_reg == 2'd2 && push), "queue overflow")
    `APS_ASSERT(a_count_step, aclk, aresetn, (push && !pop) |=> cnt_reg == $past(cnt_reg) + 2'd1,
        "queue count")
    `APS_ASSERT(a_no_underflow, aclk, aresetn, !(cnt_reg == 2'd0 && pop), "queue underflow")
endmodule
`default_nettype wire

// ----- rtl/aps_back.sv -----
// ----------------------------------------------------------------------------
// aps_back
// Command sequencer: one queued item per pass, results emitted one a cycle while accepted.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "ata_pio_command_sequencer_assert.svh"
module aps_back #(
    parameter int WORDS_PER_SECTOR = aps_pkg::WORDS_PER_SECTOR_DEF,
    parameter int MAX_BATCH        = aps_pkg::MAX_BATCH_DEF
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire aps_pkg::cfg_t  cfg,
    input  wire logic           q_valid,
    output logic                q_ready,
    input  wire aps_pkg::item_t q_item,
    output logic                m_valid,
    input  wire logic           m_ready,
    output aps_pkg::res_t       m_res
);
    import aps_pkg::*;
    localparam int WIW = $clog2(WORDS_PER_SECTOR + 1);

    typedef enum logic [10:0] {
        PH_IDLE       = 11'b00000000001,
        PH_XFER_POLL  = 11'b00000000010,
        PH_READ_DATA  = 11'b00000000100,
        PH_WRITE_WORD = 11'b00000001000,
        PH_DELAY      = 11'b00000010000,
        PH_FLUSH_POLL = 11'b00000100000,
        PH_ID_STAT0   = 11'b00001000000,
        PH_ID_POLL    = 11'b00010000000,
        PH_ID_LBA1    = 11'b00100000000,
        PH_ID_LBA2    = 11'b01000000000,
        PH_ID_DATA    = 11'b10000000000
    } phase_t;

    // sequencer micro-ops, run one a cycle while the result register is free
    typedef enum logic [3:0] {
        U_NONE, U_WR_SEL, U_WR_CNT, U_WR_L0, U_WR_L1, U_WR_L2, U_WR_CMD,
        U_POLL, U_ID_SEL, U_ID_Z2, U_ID_Z3, U_ID_Z4, U_ID_Z5, U_ID_CMD,
        U_ALT, U_BATCH_END
    } uop_t;

    phase_t      phase_reg;
    logic [1:0]  kind_reg;
    logic [27:0] lba_reg;
    logic [15:0] left_reg;
    logic [7:0]  batch_reg, sib_reg;
    logic [WIW-1:0] wi_reg;
    logic [21:0] poll_reg;
    logic [1:0]  dly_reg;
    logic [31:0] c28_reg;
    logic [63:0] c48_reg;
    logic        present_reg;
    logic        busy_reg;
    uop_t        uop_reg;
    logic        ovalid_reg;
    res_t        ores_reg;

    logic  oslot_free;
    assign oslot_free = !ovalid_reg || m_ready;
    assign m_valid = ovalid_reg;
    assign m_res   = ores_reg;
    assign q_ready = !busy_reg && oslot_free;

    function automatic res_t mk(input logic [2:0] k, input logic [2:0] op,
                                input logic [15:0] port, input logic [15:0] d,
                                input logic [15:0] hw, input logic [2:0] st,
                                input logic [47:0] sec, input logic lst);
        res_t r;
        r.kind = k; r.op = op; r.port = port; r.data = d; r.hword = hw;
        r.status = st; r.sectors = sec; r.last = lst;
        return r;
    endfunction

    function automatic logic [15:0] reg_port(input logic [15:0] base, input logic [2:0] r);
        return base + {13'd0, r};
    endfunction

    logic [7:0] b;
    logic       bsy, errf, drq, pl_hit;
    logic [21:0] pc_inc;
    logic [15:0] wv;
    logic [15:0] left_min;
    logic [7:0]  bnext;
    always_comb begin
        b      = q_item.value[7:0];
        wv     = q_item.value;
        bsy    = b[7];
        errf   = b[5] | b[0];
        drq    = b[3];
        pc_inc = (poll_reg != 22'h3FFFFF) ? poll_reg + 22'd1 : poll_reg;
        pl_hit = (pc_inc >= cfg.poll_limit);
        left_min = (left_reg > 16'(MAX_BATCH)) ? 16'(MAX_BATCH) : left_reg;
        bnext  = left_min[7:0];
    end

    logic [47:0] sec_sel;
    always_comb begin
        if (c48_reg != 64'd0)
            sec_sel = (c48_reg[63:48] != 16'd0) ? {48{1'b1}} : c48_reg[47:0];
        else
            sec_sel = {16'd0, c28_reg};
    end

    logic [7:0] sel_byte;
    assign sel_byte = SEL_LBA | (cfg.slave ? SEL_SLAVE : 8'h00) | {4'h0, lba_reg[27:24]};

    logic [27:0] lba_add;
    logic [15:0] left_sub;
    assign lba_add  = lba_reg + {20'd0, batch_reg};
    assign left_sub = left_reg - {8'd0, batch_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_IDLE;
            kind_reg    <= K_READ;
            lba_reg     <= '0;
            left_reg    <= '0;
            batch_reg   <= '0;
            sib_reg     <= '0;
            wi_reg      <= '0;
            poll_reg    <= '0;
            dly_reg     <= '0;
            c28_reg     <= '0;
            c48_reg     <= '0;
            present_reg <= 1'b0;
            busy_reg    <= 1'b0;
            uop_reg     <= U_NONE;
            ovalid_reg  <= 1'b0;
        end else begin
            if (m_ready) ovalid_reg <= 1'b0;
            if (busy_reg && oslot_free) begin
                ovalid_reg <= 1'b1;
                unique case (uop_reg)
                    U_WR_SEL: begin
                        ores_reg <= mk(RK_BUS, OP_WR8, reg_port(cfg.cmd_base, 3'd6),
                                       {8'd0, sel_byte}, '0, ST_OK, '0, 1'b0);
                        batch_reg <= bnext;
                        sib_reg   <= '0;
                        uop_reg   <= U_WR_CNT;
                    end
                    U_WR_CNT: begin
                        ores_reg <= mk(RK_BUS, OP_WR8, reg_port(cfg.cmd_base, 3'd2),
                                       {8'd0, batch_reg}, '0, ST_OK, '0, 1'b0);
                        uop_reg <= U_WR_L0;
                    end
                    U_WR_L0: begin
                        ores_reg <= mk(RK_BUS, OP_WR8, reg_port(cfg.cmd_base, 3'd3),
                                       {8'd0, lba_reg[7:0]}, '0, ST_OK, '0, 1'b0);
                        uop_reg <= U_WR_L1;
                    end
                    U_WR_L1: begin
                        ores_reg <= mk(RK_BUS, OP_WR8, reg_port(cfg.cmd_base, 3'd4),
                                       {8'd0, lba_reg[15:8]}, '0, ST_OK, '0, 1'b0);
                        uop_reg <= U_WR_L2;
                    end
                    U_WR_L2: begin
                        ores_reg <= mk(RK_BUS, OP_WR8, reg_port(cfg.cmd_base, 3'd5),
                                       {8'd0, lba_reg[23:16]}, '0, ST_OK, '0, 1'b0);
                        uop_reg <= U_WR_CMD;
                    end
                    U_WR_CMD: begin
                        ores_reg <= mk(RK_BUS, OP_WR8, reg_port(cfg.cmd_base, 3'd7),
                                       {8'd0, (kind_reg == K_WRITE) ? CMD_WR : CMD_RD},
                                       '0, ST_OK, '0, 1'b0);
                        phase_reg <= PH_XFER_POLL;
                        uop_reg   <= U_POLL;
                    end
                    U_POLL: begin
                        ores_reg <= mk(RK_BUS, OP_RD8, reg_port(cfg.cmd_base, 3'd7),
                                       '0, '0, ST_OK, '0, 1'b1);
                        poll_reg <= '0;
                        busy_reg <= 1'b0;
                        uop_reg  <= U_NONE;
                    end
                    U_ID_SEL: begin
                        ores_reg <= mk(RK_BUS, OP_WR8, reg_port(cfg.cmd_base, 3'd6),
                                       {8'd0, SEL_CHS | (cfg.slave ? SEL_SLAVE : 8'h00)},
                                       '0, ST_OK, '0, 1'b0);
                        uop_reg <= U_ALT;
                    end
                    U_ID_Z2: begin
                        ores_reg <= mk(RK_BUS, OP_WR8, reg_port(cfg.cmd_base, 3'd2),
                                       '0, '0, ST_OK, '0, 1'b0);
                        uop_reg <= U_ID_Z3;
                    end
                    U_ID_Z3: begin
                        ores_reg <= mk(RK_BUS, OP_WR8, reg_port(cfg.cmd_base, 3'd3),
                                       '0, '0, ST_OK, '0, 1'b0);
                        uop_reg <= U_ID_Z4;
                    end
                    U_ID_Z4: begin
                        ores_reg <= mk(RK_BUS, OP_WR8, reg_port(cfg.cmd_base, 3'd4),
                                       '0, '0, ST_OK, '0, 1'b0);
                        uop_reg <= U_ID_Z5;
                    end
                    U_ID_Z5: begin
                        ores_reg <= mk(RK_BUS, OP_WR8, reg_port(cfg.cmd_base, 3'd5),
                                       '0, '0, ST_OK, '0, 1'b0);
                        uop_reg <= U_ID_CMD;
                    end
                    U_ID_CMD: begin
                        ores_reg <= mk(RK_BUS, OP_WR8, reg_port(cfg.cmd_base, 3'd7),
                                       {8'd0, CMD_IDENT}, '0, ST_OK, '0, 1'b0);
                        phase_reg <= PH_ID_STAT0;
                        uop_reg   <= U_NONE;
                        busy_reg  <= 1'b1;
                        // status read follows as the last result
                        uop_reg   <= U_NONE;
                        ores_reg.last <= 1'b0;
                    end
                    U_ALT: begin
                        ores_reg <= mk(RK_BUS, OP_RD8, cfg.ctrl_base, '0, '0, ST_OK, '0, 1'b1);
                        dly_reg   <= '0;
                        phase_reg <= PH_DELAY;
                        busy_reg  <= 1'b0;
                        uop_reg   <= U_NONE;
                    end
                    U_BATCH_END: begin
                        lba_reg  <= lba_add;
                        left_reg <= left_sub;
                        ovalid_reg <= ovalid_reg && !m_ready;
                        if (left_sub != 16'd0) begin
                            uop_reg <= U_WR_SEL;
                        end else begin
                            ovalid_reg <= 1'b1;
                            ores_reg  <= mk(RK_DONE, OP_NONE, '0, '0, '0, ST_OK, '0, 1'b1);
                            phase_reg <= PH_IDLE;
                            busy_reg  <= 1'b0;
                            uop_reg   <= U_NONE;
                        end
                    end
                    default: begin
                        // identify status read after the command write
                        ores_reg <= mk(RK_BUS, OP_RD8, reg_port(cfg.cmd_base, 3'd7),
                                       '0, '0, ST_OK, '0, 1'b1);
                        busy_reg <= 1'b0;
                    end
                endcase
            end else if (q_valid && q_ready) begin
                ovalid_reg <= 1'b0;
                case (q_item.action)
                    ACT_READ, ACT_WRITE: begin
                        if (phase_reg == PH_IDLE) begin
                            kind_reg <= q_item.action[1:0];
                            ovalid_reg <= 1'b1;
                            if (q_item.sector_count == 16'd0) begin
                                ores_reg <= mk(RK_DONE, OP_NONE, '0, '0, '0, ST_INVALID, '0, 1'b1);
                            end else if (!present_reg) begin
                                ores_reg <= mk(RK_DONE, OP_NONE, '0, '0, '0, ST_NOTFOUND, '0,
                                               1'b1);
                            end else begin
                                ovalid_reg <= 1'b0;
                                lba_reg  <= q_item.lba;
                                left_reg <= q_item.sector_count;
                                busy_reg <= 1'b1;
                                uop_reg  <= U_WR_SEL;
                            end
                        end
                    end
                    ACT_IDENT: begin
                        if (phase_reg == PH_IDLE) begin
                            kind_reg    <= K_IDENT;
                            present_reg <= 1'b0;
                            busy_reg    <= 1'b1;
                            uop_reg     <= U_ID_SEL;
                        end
                    end
                    ACT_WWORD: begin
                        if (phase_reg == PH_WRITE_WORD) begin
                            ovalid_reg <= 1'b1;
                            ores_reg <= mk(RK_BUS, OP_WR16, cfg.cmd_base, wv, '0, ST_OK, '0,
                                           1'b0);
                            wi_reg   <= wi_reg + 1'b1;
                            busy_reg <= 1'b1;
                            if (wi_reg + 1'b1 < WIW'(WORDS_PER_SECTOR)) begin
                                uop_reg <= U_NONE;
                                phase_reg <= PH_WRITE_WORD;
                                ores_reg.last <= 1'b0;
                                // request follows
                                uop_reg <= U_NONE;
                            end else begin
                                uop_reg <= U_ALT;
                            end
                            if (wi_reg + 1'b1 < WIW'(WORDS_PER_SECTOR)) begin
                                busy_reg <= 1'b1;
                                uop_reg  <= U_NONE;
                                phase_reg <= PH_XFER_POLL;
                            end
                        end
                    end
                    ACT_RESP: begin
                        ovalid_reg <= 1'b1;
                        unique case (phase_reg)
                            PH_IDLE, PH_WRITE_WORD: ovalid_reg <= 1'b0;
                            PH_XFER_POLL: begin
                                poll_reg <= pc_inc;
                                if (!bsy && errf) begin
                                    ores_reg <= mk(RK_DONE, OP_NONE, '0, '0, '0, ST_DEVERR,
                                                   '0, 1'b1);
                                    phase_reg <= PH_IDLE;
                                end else if (!bsy && drq) begin
                                    wi_reg <= '0;
                                    if (kind_reg == K_WRITE) begin
                                        phase_reg <= PH_WRITE_WORD;
                                        ores_reg <= mk(RK_WREQ, OP_NONE, '0, '0, '0, ST_OK,
                                                       '0, 1'b1);
                                    end else begin
                                        phase_reg <= PH_READ_DATA;
                                        ores_reg <= mk(RK_BUS, OP_RD16, cfg.cmd_base, '0,
                                                       '0, ST_OK, '0, 1'b1);
                                    end
                                end else if (pl_hit) begin
                                    ores_reg <= mk(RK_DONE, OP_NONE, '0, '0, '0, ST_TIMEOUT,
                                                   '0, 1'b1);
                                    phase_reg <= PH_IDLE;
                                end else begin
                                    ores_reg <= mk(RK_BUS, OP_RD8,
                                                   reg_port(cfg.cmd_base, 3'd7), '0, '0,
                                                   ST_OK, '0, 1'b1);
                                end
                            end
                            PH_READ_DATA: begin
                                ores_reg <= mk(RK_HWORD, OP_NONE, '0, '0, wv, ST_OK, '0,
                                               1'b0);
                                wi_reg   <= wi_reg + 1'b1;
                                busy_reg <= 1'b1;
                                if (wi_reg + 1'b1 < WIW'(WORDS_PER_SECTOR))
                                    uop_reg <= U_NONE;
                                else
                                    uop_reg <= U_ALT;
                            end
                            PH_DELAY: begin
                                if (dly_reg < 2'd3) begin
                                    dly_reg <= dly_reg + 2'd1;
                                    ores_reg <= mk(RK_BUS, OP_RD8, cfg.ctrl_base, '0, '0,
                                                   ST_OK, '0, 1'b1);
                                end else if (kind_reg == K_IDENT) begin
                                    ovalid_reg <= 1'b0;
                                    busy_reg   <= 1'b1;
                                    uop_reg    <= U_ID_Z2;
                                end else begin
                                    sib_reg <= sib_reg + 8'd1;
                                    if (sib_reg + 8'd1 < batch_reg) begin
                                        phase_reg <= PH_XFER_POLL;
                                        poll_reg  <= '0;
                                        ores_reg <= mk(RK_BUS, OP_RD8,
                                                       reg_port(cfg.cmd_base, 3'd7), '0,
                                                       '0, ST_OK, '0, 1'b1);
                                    end else if (kind_reg == K_WRITE) begin
                                        ores_reg <= mk(RK_BUS, OP_WR8,
                                                       reg_port(cfg.cmd_base, 3'd7),
                                                       {8'd0, CMD_FLUSH}, '0, ST_OK, '0,
                                                       1'b0);
                                        phase_reg <= PH_FLUSH_POLL;
                                        busy_reg  <= 1'b1;
                                        uop_reg   <= U_POLL;
                                    end else begin
                                        ovalid_reg <= 1'b0;
                                        busy_reg   <= 1'b1;
                                        uop_reg    <= U_BATCH_END;
                                    end
                                end
                            end
                            PH_FLUSH_POLL: begin
                                poll_reg <= pc_inc;
                                if (!bsy && !errf) begin
                                    ovalid_reg <= 1'b0;
                                    busy_reg   <= 1'b1;
                                    uop_reg    <= U_BATCH_END;
                                end else if (!bsy || pl_hit) begin
                                    ores_reg <= mk(RK_DONE, OP_NONE, '0, '0, '0, ST_TIMEOUT,
                                                   '0, 1'b1);
                                    phase_reg <= PH_IDLE;
                                end else begin
                                    ores_reg <= mk(RK_BUS, OP_RD8,
                                                   reg_port(cfg.cmd_base, 3'd7), '0, '0,
                                                   ST_OK, '0, 1'b1);
                                end
                            end
                            PH_ID_STAT0: begin
                                if (b == 8'd0) begin
                                    present_reg <= 1'b0;
                                    ores_reg <= mk(RK_DONE, OP_NONE, '0, '0, '0, ST_NOTFOUND,
                                                   '0, 1'b1);
                                    phase_reg <= PH_IDLE;
                                end else begin
                                    poll_reg  <= '0;
                                    phase_reg <= PH_ID_POLL;
                                    ores_reg <= mk(RK_BUS, OP_RD8,
                                                   reg_port(cfg.cmd_base, 3'd7), '0, '0,
                                                   ST_OK, '0, 1'b1);
                                end
                            end
                            PH_ID_POLL: begin
                                poll_reg <= pc_inc;
                                if (!bsy && !errf && drq) begin
                                    phase_reg <= PH_ID_LBA1;
                                    ores_reg <= mk(RK_BUS, OP_RD8,
                                                   reg_port(cfg.cmd_base, 3'd4), '0, '0,
                                                   ST_OK, '0, 1'b1);
                                end else if ((!bsy && errf) || pl_hit) begin
                                    present_reg <= 1'b0;
                                    ores_reg <= mk(RK_DONE, OP_NONE, '0, '0, '0, ST_DEVERR,
                                                   '0, 1'b1);
                                    phase_reg <= PH_IDLE;
                                end else begin
                                    ores_reg <= mk(RK_BUS, OP_RD8,
                                                   reg_port(cfg.cmd_base, 3'd7), '0, '0,
                                                   ST_OK, '0, 1'b1);
                                end
                            end
                            PH_ID_LBA1: begin
                                c28_reg   <= {24'd0, b};
                                phase_reg <= PH_ID_LBA2;
                                ores_reg <= mk(RK_BUS, OP_RD8, reg_port(cfg.cmd_base, 3'd5),
                                               '0, '0, ST_OK, '0, 1'b1);
                            end
                            PH_ID_LBA2: begin
                                if ((c28_reg[7:0] | b) != 8'd0) begin
                                    present_reg <= 1'b0;
                                    ores_reg <= mk(RK_DONE, OP_NONE, '0, '0, '0, ST_UNSUP,
                                                   '0, 1'b1);
                                    phase_reg <= PH_IDLE;
                                end else begin
                                    c28_reg <= '0;
                                    c48_reg <= '0;
                                    wi_reg  <= '0;
                                    phase_reg <= PH_ID_DATA;
                                    ores_reg <= mk(RK_BUS, OP_RD16, cfg.cmd_base, '0, '0,
                                                   ST_OK, '0, 1'b1);
                                end
                            end
                            PH_ID_DATA: begin
                                if (wi_reg == WIW'(60)) c28_reg[15:0] <= c28_reg[15:0] | wv;
                                if (wi_reg == WIW'(61)) c28_reg[31:16] <= c28_reg[31:16] | wv;
                                if (wi_reg == WIW'(100)) c48_reg[15:0] <= wv;
                                if (wi_reg == WIW'(101)) c48_reg[31:16] <= wv;
                                if (wi_reg == WIW'(102)) c48_reg[47:32] <= wv;
                                if (wi_reg == WIW'(103)) c48_reg[63:48] <= wv;
                                wi_reg <= wi_reg + 1'b1;
                                if (wi_reg + 1'b1 < WIW'(WORDS_PER_SECTOR)) begin
                                    ores_reg <= mk(RK_BUS, OP_RD16, cfg.cmd_base, '0, '0,
                                                   ST_OK, '0, 1'b1);
                                end else begin
                                    ovalid_reg <= 1'b0;
                                    busy_reg   <= 1'b1;
                                    uop_reg    <= U_NONE;
                                    phase_reg  <= PH_IDLE;
                                end
                            end
                            default: ovalid_reg <= 1'b0;
                        endcase
                    end
                    default: ;
                endcase
            end
            // follow-up results that need no uop of their own
            if (busy_reg && oslot_free && uop_reg == U_NONE) begin
                if (phase_reg == PH_XFER_POLL && kind_reg == K_WRITE) begin
                    ores_reg <= mk(RK_WREQ, OP_NONE, '0, '0, '0, ST_OK, '0, 1'b1);
                    phase_reg <= PH_WRITE_WORD;
                end else if (phase_reg == PH_READ_DATA) begin
                    ores_reg <= mk(RK_BUS, OP_RD16, cfg.cmd_base, '0, '0, ST_OK, '0, 1'b1);
                end else if (phase_reg == PH_IDLE) begin
                    if (sec_sel == 48'd0) begin
                        present_reg <= 1'b0;
                        ores_reg <= mk(RK_DONE, OP_NONE, '0, '0, '0, ST_NOTFOUND, '0, 1'b1);
                    end else begin
                        present_reg <= 1'b1;
                        ores_reg <= mk(RK_DONE, OP_NONE, '0, '0, '0, ST_OK, sec_sel, 1'b1);
                    end
                end
            end
        end
    end

    `APS_ASSERT(a_busy_blocks, aclk, aresetn, busy_reg |-> !q_ready, "item taken while busy")
    `APS_ASSERT(a_hold, aclk, aresetn, (m_valid && !m_ready) |=> m_valid && $stable(m_res),
        "result dropped")
    `APS_ASSERT(a_bus_field, aclk, aresetn,
        (m_valid && m_res.kind == RK_DONE) |-> m_res.op == OP_NONE, "done with bus op")
endmodule
`default_nettype wire
